// ===== src/swam_pkg.sv =====
// swam_pkg: shared constants and types for the sliding window anagram matcher.
// No dependencies; used by swam_lane, swam_ram users and the top level.
package swam_pkg;

   localparam int MAX_PATTERN = 64;
   localparam int ALPHABET    = 26;

   localparam int MODE_W   = 2;
   localparam int LETTER_W = 5;
   // counts up to MAX_PATTERN inclusive
   localparam int CNT_W    = $clog2(MAX_PATTERN + 1);
   localparam int HIST_AW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   typedef enum logic [MODE_W-1:0] {
      MODE_PATTERN = 2'd0,
      MODE_TEXT    = 2'd1,
      MODE_RESTART = 2'd2,
      MODE_CLEAR   = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type            mode;
      logic [LETTER_W-1:0] letter;
   } req_type;

   typedef struct packed {
      logic window_match;
      logic any_match;
      logic pattern_overflow;
   } rsp_type;

   // per-letter count controls
   typedef struct packed {
      logic clr_pat;
      logic clr_win;
      logic pat_inc;
      logic win_inc;
      logic win_dec;
   } lane_ctl_type;

endpackage

// ===== src/swam_ram.sv =====
// swam_ram: generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
module swam_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/swam_lane.sv =====
// swam_lane: pattern and window counts of one letter, plus their equality.
// Depends on swam_pkg.
module swam_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  swam_pkg::lane_ctl_type ctl,
   output logic                   eq_next
);

   logic [swam_pkg::CNT_W-1:0] pat_cnt_ff, pat_cnt_in;
   logic [swam_pkg::CNT_W-1:0] win_cnt_ff, win_cnt_in;
   logic                       dec_ok;

   // window count never drops below zero
   assign dec_ok = ctl.win_dec && (win_cnt_ff != '0);

   always_comb begin
      if (ctl.clr_pat) begin
         pat_cnt_in = '0;
      end else if (ctl.pat_inc) begin
         pat_cnt_in = pat_cnt_ff + swam_pkg::CNT_W'(1);
      end else begin
         pat_cnt_in = pat_cnt_ff;
      end

      if (ctl.clr_win) begin
         win_cnt_in = '0;
      end else if (ctl.win_inc && !dec_ok) begin
         win_cnt_in = win_cnt_ff + swam_pkg::CNT_W'(1);
      end else if (!ctl.win_inc && dec_ok) begin
         win_cnt_in = win_cnt_ff - swam_pkg::CNT_W'(1);
      end else begin
         win_cnt_in = win_cnt_ff;
      end
   end

   assign eq_next = (pat_cnt_in == win_cnt_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_cnt_ff <= '0;
         win_cnt_ff <= '0;
      end else begin
         pat_cnt_ff <= pat_cnt_in;
         win_cnt_ff <= win_cnt_in;
      end
   end

endmodule

// ===== src/sliding_window_anagram_matcher.sv =====
// Sliding window anagram matcher: result registered at the edge that accepts
// the beat; throughput one beat per cycle while req_ready is high.
// A two-entry result buffer (output register plus skid) keeps req_ready high
// while one finished result waits on rsp_ready.
// Synchronous reset clears all counts, pointers and flags at once; the text
// history RAM is not cleared, since only entries written since the last restart are read.
module sliding_window_anagram_matcher (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  swam_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output swam_pkg::rsp_type rsp_data
);

   localparam int CW = swam_pkg::CNT_W;
   localparam int AW = swam_pkg::HIST_AW;
   localparam int LW = swam_pkg::LETTER_W;
   localparam int NL = swam_pkg::ALPHABET;

   // ---------------------------------------------------------------
   // State
   // ---------------------------------------------------------------
   logic [CW-1:0] len_ff,  len_in;     // pattern length
   logic [CW-1:0] fill_ff, fill_in;    // letters in the window
   logic [AW-1:0] ptr_ff,  ptr_in;     // next history slot
   logic          seen_ff, seen_in;    // sticky match since restart

   // history read bypass for a slot written in the same cycle it is read
   logic          byp_v_ff, byp_v_in;
   logic [LW-1:0] byp_data_ff;

   // result buffer
   logic              main_v_ff, main_v_in;
   logic              skid_v_ff, skid_v_in;
   swam_pkg::rsp_type main_ff, main_in;
   swam_pkg::rsp_type skid_ff, skid_in;

   // ---------------------------------------------------------------
   // Decode of the accepted beat
   // ---------------------------------------------------------------
   logic          accept;
   logic          letter_ok;
   logic          is_pat, is_text, is_restart, is_clear;
   logic          pat_take, pat_drop;
   logic          text_take, text_evict;
   logic [LW-1:0] old_letter, ram_rd_data;
   logic [AW-1:0] rd_addr;
   logic [CW:0]   old_diff;
   logic          match_next;
   logic [NL-1:0] lane_eq;
   swam_pkg::rsp_type rsp_new;

   assign req_ready = !skid_v_ff;
   assign accept    = req_valid && req_ready;

   assign letter_ok  = ({{(32-LW){1'b0}}, req_data.letter} < 32'(NL));
   assign is_pat     = accept && (req_data.mode == swam_pkg::MODE_PATTERN);
   assign is_text    = accept && (req_data.mode == swam_pkg::MODE_TEXT);
   assign is_restart = accept && (req_data.mode == swam_pkg::MODE_RESTART);
   assign is_clear   = accept && (req_data.mode == swam_pkg::MODE_CLEAR);

   assign pat_take   = is_pat && letter_ok && (len_ff < CW'(swam_pkg::MAX_PATTERN));
   assign pat_drop   = is_pat && letter_ok && !pat_take;
   assign text_take  = is_text && letter_ok && (len_ff != '0);
   // window full: oldest letter leaves as the new one enters
   assign text_evict = text_take && (fill_ff >= len_ff);

   assign old_letter = byp_v_ff ? byp_data_ff : ram_rd_data;

   // ---------------------------------------------------------------
   // Next state of pointers and flags
   // ---------------------------------------------------------------
   always_comb begin
      len_in  = len_ff;
      fill_in = fill_ff;
      ptr_in  = ptr_ff;
      if (is_clear) begin
         len_in  = '0;
         fill_in = '0;
         ptr_in  = '0;
      end else if (is_restart) begin
         fill_in = '0;
         ptr_in  = '0;
      end else if (pat_take) begin
         len_in = len_ff + CW'(1);
      end else if (text_take) begin
         if (!text_evict) begin
            fill_in = fill_ff + CW'(1);
         end
         if (ptr_ff == AW'(swam_pkg::MAX_PATTERN - 1)) begin
            ptr_in = '0;
         end else begin
            ptr_in = ptr_ff + AW'(1);
         end
      end
   end

   // Slot of the oldest window letter for the next beat: (ptr - fill) mod depth.
   // Read ahead so the registered RAM output is ready when the beat comes.
   always_comb begin
      old_diff = {{(CW + 1 - AW){1'b0}}, ptr_in} + (CW + 1)'(swam_pkg::MAX_PATTERN)
               - {1'b0, fill_in};
      if (old_diff >= (CW + 1)'(swam_pkg::MAX_PATTERN)) begin
         old_diff = old_diff - (CW + 1)'(swam_pkg::MAX_PATTERN);
      end
      rd_addr = old_diff[AW-1:0];
   end

   assign byp_v_in = text_take && (ptr_ff == rd_addr);

   swam_ram #(
      .WIDTH (LW),
      .DEPTH (swam_pkg::MAX_PATTERN)
   ) u_hist (
      .clock   (clock),
      .wr_en   (text_take),
      .wr_addr (ptr_ff),
      .wr_data (req_data.letter),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------
   // Letter lanes: one pair of counts per letter
   // ---------------------------------------------------------------
   for (genvar i = 0; i < NL; i++) begin : g_lane
      swam_pkg::lane_ctl_type ctl;

      always_comb begin
         ctl.clr_pat = is_clear;
         ctl.clr_win = is_clear || is_restart;
         ctl.pat_inc = pat_take && ({{(32-LW){1'b0}}, req_data.letter} == 32'(i));
         ctl.win_inc = text_take && ({{(32-LW){1'b0}}, req_data.letter} == 32'(i));
         ctl.win_dec = text_evict && ({{(32-LW){1'b0}}, old_letter} == 32'(i));
      end

      swam_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .eq_next (lane_eq[i])
      );
   end

   // all letters balanced means the window is an anagram of the pattern
   assign match_next = &lane_eq;
   assign seen_in    = ((is_clear || is_restart) ? 1'b0 : seen_ff) | match_next;

   always_comb begin
      rsp_new.window_match     = match_next;
      rsp_new.any_match        = seen_in;
      rsp_new.pattern_overflow = pat_drop;
   end

   // ---------------------------------------------------------------
   // Result buffer
   // ---------------------------------------------------------------
   always_comb begin
      main_v_in = main_v_ff;
      skid_v_in = skid_v_ff;
      main_in   = main_ff;
      skid_in   = skid_ff;
      if (main_v_ff && rsp_ready) begin
         if (skid_v_ff) begin
            main_in   = skid_ff;
            skid_v_in = 1'b0;
         end else begin
            main_v_in = accept;
            main_in   = rsp_new;
         end
      end else if (accept) begin
         if (!main_v_ff) begin
            main_v_in = 1'b1;
            main_in   = rsp_new;
         end else begin
            skid_v_in = 1'b1;
            skid_in   = rsp_new;
         end
      end
   end

   assign rsp_valid = main_v_ff;
   assign rsp_data  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         fill_ff   <= '0;
         ptr_ff    <= '0;
         seen_ff   <= 1'b0;
         byp_v_ff  <= 1'b0;
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         len_ff    <= len_in;
         fill_ff   <= fill_in;
         ptr_ff    <= ptr_in;
         byp_v_ff  <= byp_v_in;
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
         if (accept) begin
            seen_ff <= seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= req_data.letter;
      main_ff     <= main_in;
      skid_ff     <= skid_in;
   end

endmodule

// ===== tb/tb_sliding_window_anagram_matcher.sv =====
// Self-checking testbench for sliding_window_anagram_matcher: directed and random beats with
// a beat-level letter histogram predictor and a result scoreboard.
// Depends on swam_pkg (req_type, rsp_type, mode_type) and the matcher RTL.
`timescale 1ns / 1ps

module tb_sliding_window_anagram_matcher;

   // clock and reset; every DUT input starts at a known value
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   swam_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   swam_pkg::rsp_type rsp_data;

   sliding_window_anagram_matcher DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Histogram predictor: its own copy of the matcher state, at RTL widths
   // ---------------------------------------------------------------------
   logic [swam_pkg::CNT_W-1:0]    pat_cnt   [swam_pkg::ALPHABET];
   logic [swam_pkg::CNT_W-1:0]    win_cnt   [swam_pkg::ALPHABET];
   logic [swam_pkg::LETTER_W-1:0] text_hist [swam_pkg::MAX_PATTERN];
   logic [swam_pkg::HIST_AW-1:0]  hist_ptr;      // next ring slot to write
   logic [swam_pkg::CNT_W-1:0]    win_fill;
   logic [swam_pkg::CNT_W-1:0]    pat_len;
   logic [4:0]                    diff_letters;  // letters whose two counts differ
   logic                          seen_hit;

   swam_pkg::rsp_type verdicts[$];     // expected results, oldest first
   int      sent_count    = 0;
   int      fault_count   = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      hold_cycles   = 0;         // receiver hold-off, counted down per cycle

   // Keep the mismatch count in step with one letter's equality change.
   function automatic void note_letter(int c, bit was_equal);
      bit now_equal;
      now_equal = (pat_cnt[c] == win_cnt[c]);
      if (was_equal && !now_equal) begin
         diff_letters++;
      end else if (!was_equal && now_equal && diff_letters != 0) begin
         diff_letters--;
      end
   endfunction

   // Empty the window; every letter present in the pattern is now a mismatch.
   function automatic void restart_text();
      diff_letters = '0;
      for (int c = 0; c < swam_pkg::ALPHABET; c++) begin
         win_cnt[c] = '0;
         if (pat_cnt[c] != 0) begin
            diff_letters++;
         end
      end
      hist_ptr = '0;
      win_fill = '0;
      seen_hit = 1'b0;
   endfunction

   function automatic void clear_all();
      for (int c = 0; c < swam_pkg::ALPHABET; c++) begin
         pat_cnt[c] = '0;
      end
      for (int s = 0; s < swam_pkg::MAX_PATTERN; s++) begin
         text_hist[s] = '0;
      end
      pat_len = '0;
      restart_text();
   endfunction

   // Advance the predicted state by one accepted beat and return its result.
   function automatic swam_pkg::rsp_type predict_result(swam_pkg::req_type item);
      swam_pkg::rsp_type            r;
      int                           c;
      int                           prior;
      bit                           eq;
      logic [swam_pkg::HIST_AW-1:0] old_slot;
      r = '0;
      c = int'(item.letter);
      case (item.mode)
         swam_pkg::MODE_PATTERN: begin
            // out-of-alphabet letters leave everything untouched
            if (c < swam_pkg::ALPHABET) begin
               if (pat_len >= swam_pkg::MAX_PATTERN) begin
                  r.pattern_overflow = 1'b1;
               end else begin
                  eq = (pat_cnt[c] == win_cnt[c]);
                  pat_cnt[c]++;
                  pat_len++;
                  note_letter(c, eq);
               end
            end
         end
         swam_pkg::MODE_TEXT: begin
            // text with an empty pattern is ignored; the window stays empty
            if (c < swam_pkg::ALPHABET && pat_len != 0) begin
               if (win_fill >= pat_len) begin
                  // window full: oldest letter leaves through the ring
                  old_slot = hist_ptr - win_fill[swam_pkg::HIST_AW-1:0];
                  prior    = int'(text_hist[old_slot]);
                  eq       = (pat_cnt[prior] == win_cnt[prior]);
                  if (win_cnt[prior] != 0) begin
                     win_cnt[prior]--;
                  end
                  note_letter(prior, eq);
                  win_fill--;
               end
               eq = (pat_cnt[c] == win_cnt[c]);
               win_cnt[c]++;
               note_letter(c, eq);
               text_hist[hist_ptr] = c[swam_pkg::LETTER_W-1:0];
               hist_ptr++;
               win_fill++;
            end
         end
         swam_pkg::MODE_RESTART: begin
            restart_text();
         end
         default: begin
            clear_all();
         end
      endcase
      r.window_match = (diff_letters == 0);
      if (r.window_match) begin
         seen_hit = 1'b1;
      end
      r.any_match = seen_hit;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Result side: ready driver and scoreboard
   // ---------------------------------------------------------------------
   // Ready is random at recv_idle_pct, or held low while a hold-off runs.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic void report_fault(string what, swam_pkg::rsp_type want,
                                        swam_pkg::rsp_type got);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%0t: %s: expected match=%0b any=%0b ovf=%0b, %s%0b any=%0b ovf=%0b",
                  $realtime, what, want.window_match, want.any_match,
                  want.pattern_overflow, "got match=", got.window_match,
                  got.any_match, got.pattern_overflow);
      end
   endfunction

   // Values read right after the edge are the ones the edge sampled,
   // since everything here is driven through nonblocking updates.
   always @(posedge clock) begin
      swam_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdicts.size() == 0) begin
            report_fault("result beat with nothing expected", '0, rsp_data);
         end else begin
            want = verdicts.pop_front();
            if (rsp_data.window_match !== want.window_match) begin
               report_fault("window_match mismatch", want, rsp_data);
            end else if (rsp_data.any_match !== want.any_match) begin
               report_fault("any_match mismatch", want, rsp_data);
            end else if (rsp_data.pattern_overflow !== want.pattern_overflow) begin
               report_fault("pattern_overflow mismatch", want, rsp_data);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   function automatic swam_pkg::req_type make_beat(swam_pkg::mode_type m, int l);
      swam_pkg::req_type b;
      b.mode   = m;
      b.letter = l[swam_pkg::LETTER_W-1:0];
      return b;
   endfunction

   // Offer one beat, with random idle cycles before it. Valid is never
   // lowered after acceptance here: the next call (or a pause) does that,
   // so valid gets one update per time step.
   task automatic send_beat(swam_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      verdicts.push_back(predict_result(item));
      sent_count++;
   endtask

   // Sender pause: drop valid and wait until every expected result is in.
   task automatic wait_for_verdicts();
      req_valid <= 1'b0;
      do @(posedge clock); while (verdicts.size() != 0);
   endtask

   // Send the current pattern's letters as text in shuffled order, so the
   // window lines up with an anagram.
   task automatic send_anagram();
      int pool[$];
      int j;
      int t;
      for (int c = 0; c < swam_pkg::ALPHABET; c++) begin
         for (int k = 0; k < pat_cnt[c]; k++) begin
            pool.push_back(c);
         end
      end
      for (int i = pool.size() - 1; i > 0; i--) begin
         j       = $urandom_range(i);
         t       = pool[i];
         pool[i] = pool[j];
         pool[j] = t;
      end
      foreach (pool[i]) begin
         send_beat(make_beat(swam_pkg::MODE_TEXT, pool[i]));
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Extremes of both fields, every mode, and the named corner cases.
   task automatic test_directed_cases();
      send_beat(make_beat(swam_pkg::MODE_TEXT, 0));         // empty pattern: match at once
      send_beat(make_beat(swam_pkg::MODE_PATTERN, 31));     // out of alphabet, ignored
      send_beat(make_beat(swam_pkg::MODE_PATTERN, 0));
      send_beat(make_beat(swam_pkg::MODE_PATTERN, 25));
      send_beat(make_beat(swam_pkg::MODE_TEXT, 26));        // out of alphabet, ignored
      send_beat(make_beat(swam_pkg::MODE_TEXT, 25));
      send_beat(make_beat(swam_pkg::MODE_TEXT, 0));         // window {z,a}: match
      send_beat(make_beat(swam_pkg::MODE_TEXT, 1));         // z leaves, no match
      send_beat(make_beat(swam_pkg::MODE_PATTERN, 1));      // pattern grows mid-text
      send_beat(make_beat(swam_pkg::MODE_TEXT, 25));        // window grows to 3: match
      send_beat(make_beat(swam_pkg::MODE_RESTART, 0));      // sticky flag cleared
      send_beat(make_beat(swam_pkg::MODE_TEXT, 0));
      send_beat(make_beat(swam_pkg::MODE_TEXT, 1));
      send_beat(make_beat(swam_pkg::MODE_TEXT, 25));
      send_beat(make_beat(swam_pkg::MODE_CLEAR, 31));       // letter field is don't-care
      send_beat(make_beat(swam_pkg::MODE_TEXT, 5));         // empty again after clear
      send_beat(make_beat(swam_pkg::MODE_PATTERN, 16));
      send_beat(make_beat(swam_pkg::MODE_PATTERN, 15));
      send_beat(make_beat(swam_pkg::MODE_TEXT, 15));
      send_beat(make_beat(swam_pkg::MODE_TEXT, 16));
      send_beat(make_beat(swam_pkg::MODE_TEXT, 15));
      send_beat(make_beat(swam_pkg::MODE_RESTART, 21));
      send_beat(make_beat(swam_pkg::MODE_TEXT, 30));
   endtask

   // Fill the pattern to capacity, then push past it so letters are dropped;
   // a full-length anagram must then match across a wrapped ring.
   task automatic test_full_pattern();
      send_beat(make_beat(swam_pkg::MODE_CLEAR, 0));
      for (int i = 0; i < swam_pkg::MAX_PATTERN; i++) begin
         send_beat(make_beat(swam_pkg::MODE_PATTERN,
                             $urandom_range(swam_pkg::ALPHABET - 1)));
      end
      send_beat(make_beat(swam_pkg::MODE_PATTERN, $urandom_range(swam_pkg::ALPHABET - 1)));
      send_beat(make_beat(swam_pkg::MODE_PATTERN, $urandom_range(31, swam_pkg::ALPHABET)));
      send_beat(make_beat(swam_pkg::MODE_PATTERN, $urandom_range(swam_pkg::ALPHABET - 1)));
      for (int i = 0; i < 9; i++) begin
         send_beat(make_beat(swam_pkg::MODE_TEXT, $urandom_range(swam_pkg::ALPHABET - 1)));
      end
      send_anagram();
      for (int i = 0; i < 6; i++) begin
         send_beat(make_beat(swam_pkg::MODE_TEXT, $urandom_range(swam_pkg::ALPHABET - 1)));
      end
   endtask

   // Receiver stalls for a long stretch while the sender keeps offering
   // beats back to back: the result buffer fills and req_ready drops.
   task automatic test_backpressure();
      int saved_idle;
      saved_idle    = send_idle_pct;
      send_idle_pct = 0;
      hold_cycles   = 80;
      send_beat(make_beat(swam_pkg::MODE_CLEAR, 0));
      for (int i = 0; i < 3; i++) begin
         send_beat(make_beat(swam_pkg::MODE_PATTERN, $urandom_range(2)));
      end
      for (int i = 0; i < 30; i++) begin
         send_beat(make_beat(swam_pkg::MODE_TEXT, $urandom_range(2)));
      end
      send_idle_pct = saved_idle;
      wait_for_verdicts();
   endtask

   // Mostly well-formed sessions: optional clear or restart, a pattern from a
   // narrow letter range, then text from the same range with anagrams mixed
   // in. Noise beats cover stray letters, mid-text pattern growth and random
   // modes.
   task automatic test_random_sessions(int count);
      int stop_at;
      int r;
      int plen;
      int span;
      int base;
      int tlen;
      stop_at = sent_count + count;
      while (sent_count < stop_at) begin
         r = $urandom_range(99);
         if (r < 60) begin
            send_beat(make_beat(swam_pkg::MODE_CLEAR, $urandom_range(31)));
         end else if (r < 85) begin
            send_beat(make_beat(swam_pkg::MODE_RESTART, $urandom_range(31)));
         end

         r = $urandom_range(99);
         if (r < 8) begin
            plen = 0;
         end else if (r < 92) begin
            plen = $urandom_range(1, 8);
         end else begin
            plen = $urandom_range(9, swam_pkg::MAX_PATTERN + 2);
         end
         span = ($urandom_range(9) == 0) ? swam_pkg::ALPHABET : $urandom_range(2, 6);
         base = $urandom_range(swam_pkg::ALPHABET - span);

         for (int i = 0; i < plen; i++) begin
            if ($urandom_range(99) < 4) begin
               send_beat(make_beat(swam_pkg::MODE_PATTERN,
                                   $urandom_range(31, swam_pkg::ALPHABET)));
            end else begin
               send_beat(make_beat(swam_pkg::MODE_PATTERN, base + $urandom_range(span - 1)));
            end
         end

         tlen = $urandom_range(4, 30);
         for (int i = 0; i < tlen; i++) begin
            r = $urandom_range(99);
            if (r < 20 && pat_len <= 20) begin
               send_anagram();
            end else if (r < 24) begin
               send_beat(make_beat(swam_pkg::MODE_TEXT,
                                   $urandom_range(31, swam_pkg::ALPHABET)));
            end else if (r < 27) begin
               send_beat(make_beat(swam_pkg::MODE_PATTERN, base + $urandom_range(span - 1)));
            end else if (r < 29) begin
               send_beat(make_beat(swam_pkg::MODE_RESTART, $urandom_range(31)));
            end else if (r < 30) begin
               send_beat(make_beat(swam_pkg::mode_type'($urandom_range(3)),
                                   $urandom_range(31)));
            end else begin
               send_beat(make_beat(swam_pkg::MODE_TEXT, base + $urandom_range(span - 1)));
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Run order
   // ---------------------------------------------------------------------
   initial begin
      clear_all();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // sender idles now and then, receiver often
      send_idle_pct = 17;
      recv_idle_pct = 46;
      test_directed_cases();
      test_full_pattern();
      test_random_sessions(420);
      wait_for_verdicts();

      // roles swapped
      send_idle_pct = 46;
      recv_idle_pct = 17;
      test_backpressure();
      test_random_sessions(420);
      wait_for_verdicts();

      // full rate both ways
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_sessions(420);

      wait_for_verdicts();
      repeat (4) @(posedge clock);
      if (fault_count == 0 && verdicts.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: fails the run after a time far beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
